[rtl/poi_pkg.sv]
package poi_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_DEPTH = 32;
  localparam int CW = 34;  // cordic word, q2.30 with headroom

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [26:0] HEADING_SCALE = 27'sd42722830;
  localparam logic [23:0] TIMEOUT_RESET = 24'd32768;
  localparam logic [16:0] DT_MAX = 17'd65535;

  typedef enum logic [1:0] {
    OP_CMD     = 2'd0,
    OP_TICK    = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CORD_T,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_MUL5,
    ST_Q_START,
    ST_CORD_Q,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic cord_start;
    logic cord_half;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic mul5;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    cord_done;
  } dp_status_t;

  function automatic logic signed [CW-1:0] atan_at(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/poi_cordic.sv]
module poi_cordic #(
  parameter int ITERATIONS = poi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [31:0]                  angle,
  output logic                         done,
  output logic signed [poi_pkg::CW-1:0] cos_out,
  output logic signed [poi_pkg::CW-1:0] sin_out
);

  localparam int CNTW = $clog2(ITERATIONS + 1);
  localparam logic signed [poi_pkg::CW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [poi_pkg::CW-1:0] HALF = 34'sd2147483648;

  logic signed [poi_pkg::CW-1:0] x, y, z;
  logic                          flip;
  logic                          busy;
  logic [CNTW-1:0]               cnt;
  logic signed [poi_pkg::CW-1:0] z0;
  logic signed [poi_pkg::CW-1:0] dx, dy, at;

  assign z0 = {{(poi_pkg::CW-32){angle[31]}}, angle};
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = poi_pkg::atan_at(5'(cnt));
  assign done = busy && (cnt == CNTW'(ITERATIONS - 1));
  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      if (done) busy <= 1'b0;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= poi_pkg::CORDIC_GAIN_Q30;
      y <= '0;
      // fold into +-90 degrees, negate at the end
      if (z0 > QUARTER) begin
        z <= z0 - HALF;
        flip <= 1'b1;
      end else if (z0 < -QUARTER) begin
        z <= z0 + HALF;
        flip <= 1'b1;
      end else begin
        z <= z0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

endmodule

[rtl/poi_datapath.sv]
module poi_datapath #(
  parameter int ITERATIONS = poi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  poi_pkg::dp_cmd_t    cmd,
  output poi_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata,
  input  logic [79:0]         in_data,
  input  logic [2:0]          in_user,
  output logic [175:0]        out_data,
  output logic [1:0]          out_user
);

  // architectural state
  logic [31:0]        pos_x_acc, pos_y_acc, heading_acc;
  logic signed [15:0] vel_x, vel_y, yaw_rate;
  logic [31:0]        last_tick_time, last_cmd_time;
  logic [23:0]        timeout_ticks;

  // latched item
  poi_pkg::opcode_t   op;
  logic [31:0]        ts;
  logic signed [15:0] in_vx, in_vy, in_wz;
  logic               link;

  logic signed [15:0] drv_vx, drv_vy, drv_wz;
  logic               drv_valid, stop;

  logic [16:0]        dt;
  logic signed [49:0] pa, pb;
  logic signed [50:0] wx, wy;
  logic signed [33:0] hw;
  logic signed [79:0] mx, my;
  logic signed [59:0] mh;

  logic [31:0]                   d_tick, age, cord_angle;
  logic signed [79:0]            rx, ry;
  logic signed [59:0]            rh;
  logic signed [poi_pkg::CW-1:0] c, s;
  logic [15:0]                   qz, qw;

  assign status.op = op;

  assign cord_angle = cmd.cord_half ? (heading_acc >> 1) : heading_acc;

  poi_cordic #(.ITERATIONS(ITERATIONS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.cord_start),
    .angle   (cord_angle),
    .done    (status.cord_done),
    .cos_out (c),
    .sin_out (s)
  );

  assign d_tick = ts - last_tick_time;
  assign age = ts - last_cmd_time;
  assign rx = mx + (80'sd1 <<< 41);
  assign ry = my + (80'sd1 <<< 41);
  assign rh = mh + (60'sd1 <<< 23);

  function automatic logic [15:0] to_q15(input logic signed [poi_pkg::CW-1:0] v);
    logic signed [poi_pkg::CW-1:0] t;
    logic signed [poi_pkg::CW-16:0] r;
    t = v + 34'sd16384;
    r = t[poi_pkg::CW-1:15];
    if (r > 19'sd32767) return 16'h7fff;
    else if (r < -19'sd32768) return 16'h8000;
    else return r[15:0];
  endfunction

  assign qz = to_q15(s);
  assign qw = to_q15(c);

  always_ff @(posedge clk) begin
    if (rst) timeout_ticks <= poi_pkg::TIMEOUT_RESET;
    else if (cfg_we) timeout_ticks <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op <= poi_pkg::opcode_t'(in_user[1:0]);
      link <= in_user[2];
      ts <= in_data[31:0];
      in_vx <= in_data[47:32];
      in_vy <= in_data[63:48];
      in_wz <= in_data[79:64];
      drv_vx <= '0;
      drv_vy <= '0;
      drv_wz <= '0;
      drv_valid <= 1'b0;
      stop <= 1'b0;
    end else if (cmd.decode) begin
      if (op == poi_pkg::OP_CMD && link) begin
        drv_vx <= in_vx;
        drv_vy <= in_vy;
        drv_wz <= in_wz;
        drv_valid <= 1'b1;
      end
      if (op == poi_pkg::OP_TIMEOUT && age > {8'd0, timeout_ticks}) stop <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x_acc <= '0;
      pos_y_acc <= '0;
      heading_acc <= '0;
      vel_x <= '0;
      vel_y <= '0;
      yaw_rate <= '0;
      last_tick_time <= '0;
      last_cmd_time <= '0;
    end else if (cmd.decode) begin
      case (op)
        poi_pkg::OP_CMD: begin
          if (link) begin
            last_cmd_time <= ts;
            vel_x <= in_vx;
            vel_y <= in_vy;
            yaw_rate <= in_wz;
          end
        end
        poi_pkg::OP_TICK: last_tick_time <= ts;
        poi_pkg::OP_TIMEOUT: begin
          if (age > {8'd0, timeout_ticks}) begin
            vel_x <= '0;
            vel_y <= '0;
            yaw_rate <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.mul5) begin
      pos_x_acc <= pos_x_acc + rx[73:42];
      pos_y_acc <= pos_y_acc + ry[73:42];
      heading_acc <= heading_acc + rh[55:24];
    end
  end

  // world velocity and steps, products spread over the mul1 to mul4 steps
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      dt <= (d_tick > {15'd0, poi_pkg::DT_MAX}) ? poi_pkg::DT_MAX : d_tick[16:0];
    end
    if (cmd.mul1) begin
      pa <= vel_x * c;
      pb <= vel_y * s;
    end
    if (cmd.mul2) begin
      wx <= 51'(pa) - 51'(pb);
      pa <= vel_x * s;
      pb <= vel_y * c;
      hw <= yaw_rate * $signed({1'b0, dt});
    end
    if (cmd.mul3) begin
      wy <= 51'(pa) + 51'(pb);
      mx <= wx * $signed({1'b0, dt});
    end
    if (cmd.mul4) begin
      my <= wy * $signed({1'b0, dt});
      mh <= hw * poi_pkg::HEADING_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data <= {drv_wz, drv_vy, drv_vx, qw, qz, heading_acc, pos_y_acc, pos_x_acc};
      out_user <= {stop, drv_valid};
    end
  end

endmodule

[rtl/poi_ctrl.sv]
module poi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output poi_pkg::dp_cmd_t    cmd,
  input  poi_pkg::dp_status_t status
);

  poi_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == poi_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= poi_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.fin) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      poi_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = poi_pkg::ST_DECODE;
        end
      end
      poi_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        if (status.op == poi_pkg::OP_TICK) begin
          cmd.cord_start = 1'b1;
          state_next = poi_pkg::ST_CORD_T;
        end else begin
          state_next = poi_pkg::ST_Q_START;
        end
      end
      poi_pkg::ST_CORD_T: if (status.cord_done) state_next = poi_pkg::ST_MUL1;
      poi_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = poi_pkg::ST_MUL2;
      end
      poi_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = poi_pkg::ST_MUL3;
      end
      poi_pkg::ST_MUL3: begin
        cmd.mul3 = 1'b1;
        state_next = poi_pkg::ST_MUL4;
      end
      poi_pkg::ST_MUL4: begin
        cmd.mul4 = 1'b1;
        state_next = poi_pkg::ST_MUL5;
      end
      poi_pkg::ST_MUL5: begin
        cmd.mul5 = 1'b1;
        state_next = poi_pkg::ST_Q_START;
      end
      poi_pkg::ST_Q_START: begin
        cmd.cord_start = 1'b1;
        cmd.cord_half = 1'b1;
        state_next = poi_pkg::ST_CORD_Q;
      end
      poi_pkg::ST_CORD_Q: if (status.cord_done) state_next = poi_pkg::ST_FIN;
      poi_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.fin = 1'b1;
          state_next = poi_pkg::ST_IDLE;
        end
      end
      default: state_next = poi_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/planar_odometry_integrator.sv]
// dead-reckoning pose integrator for a holonomic base
// input stream: one beat per item, opcode selects velocity command, odometry
// tick or timeout check; every beat yields exactly one output beat carrying
// the pose, the yaw quaternion and the drive velocities
// one item at a time: s_axis_tready is high only while the sequencer idles
// path from accept to m_axis_tvalid: decode; for a tick a cordic run on the
// heading and the mul1 to mul5 product and integration steps; for every item
// a cordic run on the half heading, then the fin step, which waits until the
// output register is free; the shared iterative cordic unit, one rotation
// per cycle, does both runs
// the output beat sits in a register; the next item is accepted while it
// waits, and a stalled receiver holds the next result in its last step
// cfg_we writes timeout_ticks at once; writing only while the block is idle is the user's duty, unchecked by the block
// synchronous reset clears pose, velocities, timestamps, sets timeout_ticks
// to 32768 and drops m_axis_tvalid
module planar_odometry_integrator #(
  parameter int CORDIC_ITERATIONS = poi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // timestamp, cmd_vx, cmd_vy, cmd_wz
  input  logic [79:0]  s_axis_tdata,
  // opcode[1:0], link_up
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, heading, quat_z, quat_w, drive_vx, drive_vy, drive_wz
  output logic [175:0] m_axis_tdata,
  // drive_valid, stop_issued
  output logic [1:0]   m_axis_tuser
);

  poi_pkg::dp_cmd_t    cmd;
  poi_pkg::dp_status_t status;

  poi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  poi_datapath #(.ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

[rtl/poi_checker.sv]
module poi_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // one item in flight
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item accepted while busy");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("drive and stop in one beat");

  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[175:128] == 48'd0)
    else $error("drive fields set without drive_valid");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 800;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [23:0] TIMEOUT_MAX = 24'hFFFFFF;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hdg;
    logic [15:0] qz;
    logic [15:0] qw;
    logic [15:0] dvx;
    logic [15:0] dvy;
    logic [15:0] dwz;
    logic        dvalid;
    logic        stop;
  } pose_t;

  typedef struct {
    poi_pkg::opcode_t op;
    logic [31:0]      ts;
    logic [15:0]      vx;
    logic [15:0]      vy;
    logic [15:0]      wz;
    logic             link;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  planar_odometry_integrator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] pos_x_q, pos_y_q, heading_q;
  logic signed [15:0] vel_x_q, vel_y_q, yaw_q;
  logic [31:0] tick_time_q, cmd_time_q;
  logic [23:0] timeout_q;

  pose_t poses_due[$];
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_sink = 0;
  bit in_hold = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_ba(int i);
    longint t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ang));
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < poi_pkg::CORDIC_ITERATIONS_DEF && i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_ba(i);
      end else begin
        x += dx; y -= dy; z += atan_ba(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [15:0] half_q15(longint v);
    longint r;
    r = floor_shr(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic integrate_item(input item_t it, output pose_t p);
    longint c, s, wx, wy, dt, ddx, ddy, ddh;
    logic [31:0] d;
    p = '{default: '0};
    case (it.op)
      poi_pkg::OP_CMD: begin
        if (it.link) begin
          cmd_time_q = it.ts;
          vel_x_q = it.vx; vel_y_q = it.vy; yaw_q = it.wz;
          p.dvx = it.vx; p.dvy = it.vy; p.dwz = it.wz;
          p.dvalid = 1'b1;
        end
      end
      poi_pkg::OP_TICK: begin
        d = it.ts - tick_time_q;
        dt = (d > 32'd65535) ? 65535 : longint'(d);
        tick_time_q = it.ts;
        rotate_unit(heading_q, c, s);
        wx = longint'(vel_x_q) * c - longint'(vel_y_q) * s;
        wy = longint'(vel_x_q) * s + longint'(vel_y_q) * c;
        ddx = floor_shr(wx * dt + (64'sd1 <<< 41), 42);
        ddy = floor_shr(wy * dt + (64'sd1 <<< 41), 42);
        ddh = floor_shr(longint'(yaw_q) * dt * 42722830 + (64'sd1 <<< 23), 24);
        pos_x_q += ddx[31:0];
        pos_y_q += ddy[31:0];
        heading_q += ddh[31:0];
      end
      poi_pkg::OP_TIMEOUT: begin
        if ((it.ts - cmd_time_q) > {8'd0, timeout_q}) begin
          vel_x_q = 0; vel_y_q = 0; yaw_q = 0;
          p.stop = 1'b1;
        end
      end
      default: ;
    endcase
    rotate_unit(heading_q >> 1, c, s);
    p.px = pos_x_q; p.py = pos_y_q; p.hdg = heading_q;
    p.qz = half_q15(s); p.qw = half_q15(c);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // output side: stall pattern plus the long hold-off
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    pose_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (poses_due.size() == 0) begin
        errors++;
        $display("unexpected result beat");
      end else begin
        w = poses_due.pop_front();
        if (m_axis_tdata[31:0] !== w.px) report("pos_x", m_axis_tdata[31:0], w.px);
        if (m_axis_tdata[63:32] !== w.py) report("pos_y", m_axis_tdata[63:32], w.py);
        if (m_axis_tdata[95:64] !== w.hdg) report("heading", m_axis_tdata[95:64], w.hdg);
        if (m_axis_tdata[111:96] !== w.qz) report("quat_z", m_axis_tdata[111:96], w.qz);
        if (m_axis_tdata[127:112] !== w.qw) report("quat_w", m_axis_tdata[127:112], w.qw);
        if (m_axis_tdata[143:128] !== w.dvx) report("drive_vx", m_axis_tdata[143:128], w.dvx);
        if (m_axis_tdata[159:144] !== w.dvy) report("drive_vy", m_axis_tdata[159:144], w.dvy);
        if (m_axis_tdata[175:160] !== w.dwz) report("drive_wz", m_axis_tdata[175:160], w.dwz);
        if (m_axis_tuser[0] !== w.dvalid) report("drive_valid", m_axis_tuser[0], w.dvalid);
        if (m_axis_tuser[1] !== w.stop) report("stop_issued", m_axis_tuser[1], w.stop);
      end
    end
  end

  // long receiver hold-off, counted here while items keep coming
  always @(negedge clk) begin
    if (in_hold && !hold_sink) begin
      hold_sink <= 1'b1;
      repeat (600) @(negedge clk);
      hold_sink <= 1'b0;
      in_hold <= 1'b0;
    end
  end

  // valid stays up after a beat until the next negedge decides
  task automatic send_item(input item_t it, input bit typed, input pose_t typed_pose);
    pose_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {it.wz, it.vy, it.vx, it.ts};
    s_axis_tuser <= {it.link, it.op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    integrate_item(it, p);
    poses_due.push_back(typed ? typed_pose : p);
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (poses_due.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [23:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_q = v;
  endtask

  function automatic item_t mk(poi_pkg::opcode_t op, logic [31:0] ts, logic [15:0] vx,
                               logic [15:0] vy, logic [15:0] wz, logic link);
    item_t it;
    it.op = op; it.ts = ts; it.vx = vx; it.vy = vy; it.wz = wz; it.link = link;
    return it;
  endfunction

  function automatic item_t rand_item(logic [31:0] now);
    item_t it;
    int r;
    r = $urandom_range(99);
    it.ts = now;
    it.vx = 16'($urandom); it.vy = 16'($urandom); it.wz = 16'($urandom);
    it.link = ($urandom_range(9) != 0);
    if (r < 30) it.op = poi_pkg::OP_CMD;
    else if (r < 80) it.op = poi_pkg::OP_TICK;
    else if (r < 95) it.op = poi_pkg::OP_TIMEOUT;
    else it.op = poi_pkg::OP_NONE;
    return it;
  endfunction

  item_t directed [$];
  pose_t zero_pose;

  initial begin
    item_t it;
    logic [31:0] now;
    pos_x_q = 0; pos_y_q = 0; heading_q = 0;
    vel_x_q = 0; vel_y_q = 0; yaw_q = 0;
    tick_time_q = 0; cmd_time_q = 0;
    timeout_q = poi_pkg::TIMEOUT_RESET;
    zero_pose = '{default: '0};
    zero_pose.qw = 16'h7fff;
    // the cordic residue at zero angle leaves the sine one lsb below zero
    zero_pose.qz = 16'hffff;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first beats after reset: pose at zero
    send_item(mk(poi_pkg::OP_NONE, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0), 1, zero_pose);
    send_item(mk(poi_pkg::OP_TICK, 32'h0, 16'hffff, 16'hffff, 16'hffff, 1'b1), 0, zero_pose);
    directed = '{
      mk(poi_pkg::OP_CMD, 32'h100, 16'h7fff, 16'h8000, 16'h7fff, 1'b0),
      mk(poi_pkg::OP_CMD, 32'h200, 16'h7fff, 16'h8000, 16'h7fff, 1'b1),
      mk(poi_pkg::OP_TICK, 32'h300, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TICK, 32'hffff_ff00, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TICK, 32'h0000_0100, 16'h0, 16'h0, 16'h0, 1'b1),
      mk(poi_pkg::OP_CMD, 32'h400, 16'h8000, 16'h7fff, 16'h8000, 1'b1),
      mk(poi_pkg::OP_TICK, 32'h1_0400, 16'hffff, 16'hffff, 16'hffff, 1'b1),
      mk(poi_pkg::OP_TICK, 32'h2_0400, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TIMEOUT, 32'h8400, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TIMEOUT, 32'h8401, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TIMEOUT, 32'h9000, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_TICK, 32'h3_0000, 16'h0, 16'h0, 16'h0, 1'b0),
      mk(poi_pkg::OP_CMD, 32'hffff_ffff, 16'h1000, 16'h0, 16'h4000, 1'b1),
      mk(poi_pkg::OP_TIMEOUT, 32'h0000_7fff, 16'h0, 16'h0, 16'h0, 1'b1),
      mk(poi_pkg::OP_NONE, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 1'b1)
    };
    foreach (directed[i]) send_item(directed[i], 0, zero_pose);

    set_timeout(24'd0);
    send_item(mk(poi_pkg::OP_TIMEOUT, 32'hffff_ffff, 16'h0, 16'h0, 16'h0, 1'b0), 0,
              zero_pose);
    set_timeout(TIMEOUT_MAX);
    send_item(mk(poi_pkg::OP_TIMEOUT, 32'h0100_0000, 16'h0, 16'h0, 16'h0, 1'b0), 0,
              zero_pose);

    now = $urandom;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      case (n / 100)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 81; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 81; end
        3: begin src_idle_pct = 6; snk_stall_pct = 6; end
        default: begin src_idle_pct = $urandom_range(10); snk_stall_pct = $urandom_range(10); end
      endcase
      if (n == 450) in_hold = 1'b1;
      if (n % 200 == 199) set_timeout($urandom_range(1) ? 24'($urandom) : 24'($urandom_range(4000)));
      // mostly small steps, sometimes big jumps to hit saturation and wrap
      now += ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
      it = rand_item(now);
      send_item(it, 0, zero_pose);
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    s_axis_tvalid <= 1'b0;
    while (poses_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/poi_pkg.sv
rtl/poi_cordic.sv
rtl/poi_datapath.sv
rtl/poi_ctrl.sv
rtl/planar_odometry_integrator.sv
rtl/poi_checker.sv
tb/tb_top.sv
